// ----- src/vpp_pkg.sv -----
// Shared types and constants for the valve pulse positioner.
// Used by the config register bank, the step core and the top level.
package vpp_pkg;

  typedef enum logic [1:0] {
    MOTION_HOLD  = 2'd0,
    MOTION_RAISE = 2'd1,
    MOTION_LOWER = 2'd2
  } motion_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] REG_RISE_DEADBAND    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_RISE_STEP_MAX    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_FALL_DEADBAND    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_FALL_STEP_MAX    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_HOLD_TICKS       = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_RISE_EXTRA_TICKS = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_FALL_EXTRA_TICKS = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_PRESSURE_FLOOR   = 3'd7;

  typedef struct packed {
    logic [14:0] rise_deadband;
    logic [14:0] rise_step_max;
    logic [14:0] fall_deadband;
    logic [14:0] fall_step_max;
    logic [15:0] hold_ticks;
    logic [11:0] rise_extra_ticks;
    logic [11:0] fall_extra_ticks;
    logic [15:0] pressure_floor;
  } cfg_t;

  typedef struct packed {
    logic        open_pilot;
    logic        close_pilot;
    motion_e     motion_code;
    logic [14:0] opening_estimate;
    logic        target_snap;
    logic [14:0] snapped_target;
  } result_t;

  localparam logic [15:0] PulseTicksReset = 16'd400;

endpackage

// ----- src/vpp_cfg_regs.sv -----
// Configuration register bank of the valve pulse positioner.
// Depends on vpp_pkg for the register indexes and the cfg_t bundle.
module vpp_cfg_regs import vpp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RISE_DEADBAND:    cfg_d.rise_deadband    = cfg_data_i[14:0];
        REG_RISE_STEP_MAX:    cfg_d.rise_step_max    = cfg_data_i[14:0];
        REG_FALL_DEADBAND:    cfg_d.fall_deadband    = cfg_data_i[14:0];
        REG_FALL_STEP_MAX:    cfg_d.fall_step_max    = cfg_data_i[14:0];
        REG_HOLD_TICKS:       cfg_d.hold_ticks       = cfg_data_i;
        REG_RISE_EXTRA_TICKS: cfg_d.rise_extra_ticks = cfg_data_i[11:0];
        REG_FALL_EXTRA_TICKS: cfg_d.fall_extra_ticks = cfg_data_i[11:0];
        REG_PRESSURE_FLOOR:   cfg_d.pressure_floor   = cfg_data_i;
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rise_deadband    <= 15'd50;
      cfg_q.rise_step_max    <= 15'd400;
      cfg_q.fall_deadband    <= 15'd50;
      cfg_q.fall_step_max    <= 15'd400;
      cfg_q.hold_ticks       <= 16'd400;
      cfg_q.rise_extra_ticks <= 12'd30;
      cfg_q.fall_extra_ticks <= 12'd30;
      cfg_q.pressure_floor   <= 16'd50;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- src/vpp_core.sv -----
// Positioner state machine: motion state, tick counter, opening estimate
// and pulse lengths, advanced once per tick item. Depends on vpp_pkg.
module vpp_core import vpp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [14:0] target_opening_i,
  input  logic [15:0] line_pressure_i,
  input  logic        start_window_i,
  input  cfg_t        cfg_i,
  output result_t     result_o
);

  motion_e     state_q, state_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic [14:0] pos_q, pos_d;
  logic [15:0] rise_len_q, rise_len_d;
  logic [15:0] fall_len_q, fall_len_d;
  logic        snap;
  logic [14:0] snap_val;

  logic [15:0] elapsed_inc;
  logic [16:0] rise_diff, fall_diff;
  logic        rise_req, fall_req, rise_clamp, fall_clamp, low_press, hold_done;
  logic [14:0] rise_step, fall_step;
  logic [14:0] pos_up, pos_down;

  always_comb begin
    elapsed_inc = (elapsed_q != 16'hFFFF) ? elapsed_q + 16'd1 : elapsed_q;
    rise_diff   = {2'b00, target_opening_i} - {2'b00, pos_q};
    fall_diff   = {2'b00, pos_q} - {2'b00, target_opening_i};
    rise_req    = !rise_diff[16] && (rise_diff[15:0] > {1'b0, cfg_i.rise_deadband});
    fall_req    = !fall_diff[16] && (fall_diff[15:0] > {1'b0, cfg_i.fall_deadband});
    rise_clamp  = rise_diff[14:0] > cfg_i.rise_step_max;
    fall_clamp  = fall_diff[14:0] > cfg_i.fall_step_max;
    rise_step   = rise_clamp ? cfg_i.rise_step_max : rise_diff[14:0];
    fall_step   = fall_clamp ? cfg_i.fall_step_max : fall_diff[14:0];
    pos_up      = pos_q + rise_step;
    pos_down    = pos_q - fall_step;
    low_press   = line_pressure_i < cfg_i.pressure_floor;
    hold_done   = elapsed_inc > cfg_i.hold_ticks;
  end

  // Next state
  always_comb begin
    state_d    = state_q;
    elapsed_d  = elapsed_inc;
    pos_d      = pos_q;
    rise_len_d = rise_len_q;
    fall_len_d = fall_len_q;
    snap       = 1'b0;
    snap_val   = '0;
    if (start_window_i) begin
      // force lower; estimate left alone, counter keeps counting
      state_d = MOTION_LOWER;
    end else begin
      case (state_q)
        MOTION_HOLD: begin
          if (hold_done && rise_req) begin
            if (low_press) begin
              snap     = 1'b1;
              snap_val = pos_q;
            end else begin
              state_d    = MOTION_RAISE;
              elapsed_d  = '0;
              pos_d      = pos_up;
              rise_len_d = {1'b0, rise_step} + {4'd0, cfg_i.rise_extra_ticks};
              snap       = rise_clamp;
              snap_val   = rise_clamp ? pos_up : '0;
            end
          end else if (hold_done && fall_req) begin
            state_d    = MOTION_LOWER;
            elapsed_d  = '0;
            pos_d      = pos_down;
            fall_len_d = {1'b0, fall_step} + {4'd0, cfg_i.fall_extra_ticks};
            snap       = fall_clamp;
            snap_val   = fall_clamp ? pos_down : '0;
          end
        end
        MOTION_RAISE: begin
          if (elapsed_inc > rise_len_q) begin
            state_d   = MOTION_HOLD;
            elapsed_d = '0;
          end
        end
        MOTION_LOWER: begin
          if (elapsed_inc > fall_len_q) begin
            state_d   = MOTION_HOLD;
            elapsed_d = '0;
          end
        end
        default: begin
          state_d   = MOTION_HOLD;
          elapsed_d = '0;
        end
      endcase
    end
  end

  // Outputs follow the new state
  always_comb begin
    result_o.open_pilot       = (state_d == MOTION_HOLD) || (state_d == MOTION_RAISE);
    result_o.close_pilot      = (state_d == MOTION_RAISE);
    result_o.motion_code      = state_d;
    result_o.opening_estimate = pos_d;
    result_o.target_snap      = snap;
    result_o.snapped_target   = snap_val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= MOTION_HOLD;
      elapsed_q  <= '0;
      pos_q      <= '0;
      rise_len_q <= PulseTicksReset;
      fall_len_q <= PulseTicksReset;
    end else if (step_i) begin
      state_q    <= state_d;
      elapsed_q  <= elapsed_d;
      pos_q      <= pos_d;
      rise_len_q <= rise_len_d;
      fall_len_q <= fall_len_d;
    end
  end

endmodule

// ----- src/valve_pulse_positioner.sv -----
// Top level of the valve pulse positioner: input register, step core,
// result register and configuration bank. Depends on vpp_pkg.

// One item is one millisecond tick. The block takes an item every clock while
// the output is not stalled, and returns its result through the input
// register, then the result register; the hold/raise/lower state, tick
// counter and opening estimate close their loop through the core's compare
// and add logic, so back-to-back items see each other's updates. The pilot
// outputs and motion code reflect the state after the tick; when a raise is
// refused for low line pressure or a step is clamped, target_snap is set and
// snapped_target carries the replacement target (zero otherwise). Write the
// configuration registers only while no item is in flight.
module valve_pulse_positioner import vpp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [14:0]         target_opening_i,
  input  logic [15:0]         line_pressure_i,
  input  logic                start_window_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                open_pilot_o,
  output logic                close_pilot_o,
  output logic [1:0]          motion_code_o,
  output logic [14:0]         opening_estimate_o,
  output logic                target_snap_o,
  output logic [14:0]         snapped_target_o
);

  cfg_t        cfg;
  result_t     result, res_q;
  logic        in_valid_q, out_valid_q;
  logic [14:0] target_q;
  logic [15:0] pressure_q;
  logic        window_q;
  logic        out_free, advance, accept;

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;
  assign accept     = in_valid_i && in_ready_o;

  vpp_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  vpp_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (advance),
    .target_opening_i (target_q),
    .line_pressure_i  (pressure_q),
    .start_window_i   (window_q),
    .cfg_i            (cfg),
    .result_o         (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      target_q   <= target_opening_i;
      pressure_q <= line_pressure_i;
      window_q   <= start_window_i;
    end
    if (advance) begin
      res_q <= result;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign open_pilot_o       = res_q.open_pilot;
  assign close_pilot_o      = res_q.close_pilot;
  assign motion_code_o      = res_q.motion_code;
  assign opening_estimate_o = res_q.opening_estimate;
  assign target_snap_o      = res_q.target_snap;
  assign snapped_target_o   = res_q.snapped_target;

endmodule
